@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the lookup block RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

@@ rtl/core/mtrr_pkg.sv @@
// Shared types, codes and helpers for the memory type lookup block.
`timescale 1ns / 1ps
`default_nettype none

package mtrr_pkg;

    localparam int VAR_RANGES_DEF = 8;
    localparam int PHYS_BITS_DEF  = 52;
    localparam int FIXED_REGS     = 11;
    localparam int PAGE_SHIFT     = 12;
    localparam int RANGE_IDX_W    = 4;

    localparam logic [1:0] CMD_LOOKUP    = 2'd0;
    localparam logic [1:0] CMD_WR_FIXED  = 2'd1;
    localparam logic [1:0] CMD_WR_BASE   = 2'd2;
    localparam logic [1:0] CMD_WR_MASK   = 2'd3;

    localparam logic [1:0] CFG_MTRR_ENABLE  = 2'd0;
    localparam logic [1:0] CFG_FIXED_ENABLE = 2'd1;
    localparam logic [1:0] CFG_DEFAULT_TYPE = 2'd2;

    localparam logic [2:0] TYPE_UC = 3'd0;
    localparam logic [2:0] TYPE_WT = 3'd4;
    localparam logic [2:0] TYPE_WB = 3'd6;

    localparam logic [1:0] SRC_DISABLED = 2'd0;
    localparam logic [1:0] SRC_FIXED    = 2'd1;
    localparam logic [1:0] SRC_VARIABLE = 2'd2;
    localparam logic [1:0] SRC_DEFAULT  = 2'd3;

    typedef struct packed {
        logic                   capture;
        logic                   step;
        logic                   publish;
        logic [RANGE_IDX_W-1:0] index;
    } dp_cmd_t;

    typedef struct packed {
        logic lookup;
        logic direct;
    } dp_status_t;

    typedef struct packed {
        logic       ok;
        logic [2:0] mem_type;
    } combine_t;

    function automatic combine_t combine_types(input logic [2:0] a, input logic [2:0] b);
        combine_t r;
        r.ok       = 1'b1;
        r.mem_type = a;
        if (a == b) begin
            r.mem_type = a;
        end else if (a == TYPE_UC || b == TYPE_UC) begin
            r.mem_type = TYPE_UC;
        end else if ((a == TYPE_WB && b == TYPE_WT) || (a == TYPE_WT && b == TYPE_WB)) begin
            r.mem_type = TYPE_WT;
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/mtrr_ctl.sv @@
// Controller: sequences capture, range scan and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mtrr_ctl
    import mtrr_pkg::*;
#(
    parameter int VAR_RANGES = VAR_RANGES_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  wire logic       out_stall,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    localparam int IDX_W = (VAR_RANGES > 1) ? $clog2(VAR_RANGES) : 1;
    localparam logic [IDX_W-1:0] LAST_RANGE = IDX_W'(VAR_RANGES - 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } ctl_state_t;

    ctl_state_t       state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.index  = RANGE_IDX_W'(cnt_reg);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    if (status.lookup)
                    begin
                        if (status.direct)
                        begin
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                            cnt_next   = '0;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.step = 1'b1;
                if (cnt_reg == LAST_RANGE)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.publish ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ASSERT_ALWAYS(a_publish_free, cmd.publish |-> out_free, "result published over a held item")
    `ASSERT_NEXT(a_publish_valid, cmd.publish, out_valid_reg, "published item not presented")
    `ASSERT_NEXT(a_lookup_busy, in_valid && !in_stall && status.lookup, state_reg != ST_IDLE,
        "accepted lookup left controller idle")
    `ASSERT_NEXT(a_scan_end, state_reg == ST_SCAN && cnt_reg == LAST_RANGE,
        state_reg == ST_FINISH, "range scan overran last range")

endmodule

`default_nettype wire

@@ rtl/core/mtrr_dp.sv @@
// Datapath: range registers, fixed-range select, range combine and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mtrr_dp
    import mtrr_pkg::*;
#(
    parameter int VAR_RANGES = VAR_RANGES_DEF,
    parameter int PHYS_BITS  = PHYS_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [2:0]  cfg_data,
    input  wire logic [1:0]  command,
    input  wire logic [3:0]  reg_index,
    input  wire logic [63:0] write_data,
    input  wire logic [51:0] address,
    input  wire dp_cmd_t     cmd,
    output dp_status_t       status,
    output logic [2:0]       memory_type,
    output logic             undefined,
    output logic [1:0]       source
);

    localparam int PAGE_W = PHYS_BITS - PAGE_SHIFT;
    localparam int IDX_W  = (VAR_RANGES > 1) ? $clog2(VAR_RANGES) : 1;
    localparam logic [4:0] RANGE_LIMIT = 5'(VAR_RANGES);
    localparam logic [3:0] FIXED_LIMIT = 4'(FIXED_REGS);

    logic              mtrr_enable_reg;
    logic              fixed_enable_reg;
    logic [2:0]        default_type_reg;

    logic [63:0]       fixed_reg [FIXED_REGS];
    logic [PAGE_W-1:0] base_page_reg [VAR_RANGES];
    logic [2:0]        base_type_reg [VAR_RANGES];
    logic [PAGE_W-1:0] mask_page_reg [VAR_RANGES];
    logic              mask_valid_reg [VAR_RANGES];

    logic [PAGE_W-1:0] page_reg;
    logic [2:0]        acc_type_reg;
    logic [1:0]        acc_src_reg;
    logic              acc_hit_reg;
    logic              acc_undef_reg;
    logic [2:0]        out_type_reg;
    logic              out_undef_reg;
    logic [1:0]        out_src_reg;

    logic              below_1m;
    logic [3:0]        fix_sel;
    logic [2:0]        fix_byte;
    logic [63:0]       fix_word;
    logic [2:0]        fix_type;
    logic [IDX_W-1:0]  scan_idx;
    logic              range_hit;
    combine_t          comb;
    logic [IDX_W-1:0]  wr_idx;
    logic              var_wr_ok;

    assign below_1m = (address[PHYS_BITS-1:20] == '0);

    // 64K layout below 512K, 16K layout to 768K, 4K layout to 1M.
    always_comb
    begin
        if (!address[19])
        begin
            fix_sel  = 4'd0;
            fix_byte = address[18:16];
        end
        else if (!address[18])
        begin
            fix_sel  = address[17] ? 4'd2 : 4'd1;
            fix_byte = address[16:14];
        end
        else
        begin
            fix_sel  = 4'd3 + {1'b0, address[17:15]};
            fix_byte = address[14:12];
        end
    end

    assign fix_word = fixed_reg[fix_sel];
    assign fix_type = fix_word[{fix_byte, 3'b000} +: 3];

    assign status.lookup = (command == CMD_LOOKUP);
    assign status.direct = !mtrr_enable_reg || (fixed_enable_reg && below_1m);

    assign scan_idx  = cmd.index[IDX_W-1:0];
    assign range_hit = mask_valid_reg[scan_idx] &&
        ((page_reg & mask_page_reg[scan_idx]) == (base_page_reg[scan_idx] & mask_page_reg[scan_idx]));
    assign comb      = combine_types(acc_type_reg, base_type_reg[scan_idx]);

    assign wr_idx    = reg_index[IDX_W-1:0];
    assign var_wr_ok = ({1'b0, reg_index} < RANGE_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mtrr_enable_reg  <= 1'b0;
            fixed_enable_reg <= 1'b0;
            default_type_reg <= TYPE_UC;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MTRR_ENABLE:  mtrr_enable_reg  <= cfg_data[0];
                CFG_FIXED_ENABLE: fixed_enable_reg <= cfg_data[0];
                CFG_DEFAULT_TYPE: default_type_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FIXED_REGS; i++)
            begin
                fixed_reg[i] <= '0;
            end
            for (int i = 0; i < VAR_RANGES; i++)
            begin
                base_page_reg[i]  <= '0;
                base_type_reg[i]  <= '0;
                mask_page_reg[i]  <= '0;
                mask_valid_reg[i] <= 1'b0;
            end
        end
        else if (cmd.capture)
        begin
            case (command)
                CMD_WR_FIXED:
                begin
                    if (reg_index < FIXED_LIMIT)
                    begin
                        fixed_reg[reg_index] <= write_data;
                    end
                end
                CMD_WR_BASE:
                begin
                    if (var_wr_ok)
                    begin
                        base_page_reg[wr_idx] <= write_data[PHYS_BITS-1:PAGE_SHIFT];
                        base_type_reg[wr_idx] <= write_data[2:0];
                    end
                end
                CMD_WR_MASK:
                begin
                    if (var_wr_ok)
                    begin
                        mask_page_reg[wr_idx]  <= write_data[PHYS_BITS-1:PAGE_SHIFT];
                        mask_valid_reg[wr_idx] <= write_data[11];
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_hit_reg   <= 1'b0;
            acc_undef_reg <= 1'b0;
        end
        else if (cmd.capture && status.lookup)
        begin
            acc_hit_reg   <= 1'b0;
            acc_undef_reg <= 1'b0;
        end
        else if (cmd.step && range_hit)
        begin
            if (!acc_hit_reg)
            begin
                acc_hit_reg <= 1'b1;
            end
            else if (!acc_undef_reg && !comb.ok)
            begin
                acc_undef_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture && status.lookup)
        begin
            page_reg <= address[PHYS_BITS-1:PAGE_SHIFT];
            if (!mtrr_enable_reg)
            begin
                acc_type_reg <= TYPE_UC;
                acc_src_reg  <= SRC_DISABLED;
            end
            else if (fixed_enable_reg && below_1m)
            begin
                acc_type_reg <= fix_type;
                acc_src_reg  <= SRC_FIXED;
            end
            else
            begin
                acc_type_reg <= default_type_reg;
                acc_src_reg  <= SRC_DEFAULT;
            end
        end
        else if (cmd.step && range_hit)
        begin
            if (!acc_hit_reg)
            begin
                acc_type_reg <= base_type_reg[scan_idx];
                acc_src_reg  <= SRC_VARIABLE;
            end
            else if (!acc_undef_reg && comb.ok)
            begin
                acc_type_reg <= comb.mem_type;
            end
        end
        if (cmd.publish)
        begin
            out_type_reg  <= acc_undef_reg ? TYPE_UC : acc_type_reg;
            out_undef_reg <= acc_undef_reg;
            out_src_reg   <= acc_src_reg;
        end
    end

    assign memory_type = out_type_reg;
    assign undefined   = out_undef_reg;
    assign source      = out_src_reg;

    `ASSERT_ALWAYS(a_undef_needs_hit, acc_undef_reg |-> acc_hit_reg,
        "undefined flag set without a matching range")

endmodule

`default_nettype wire

@@ rtl/core/mtrr_memory_type_lookup.sv @@
// Top level of the memory type lookup block: controller and datapath.
//
//   channel   direction  handshake               payload
//   in        in         in_valid / in_stall     command, reg_index, write_data, address
//   out       out        out_valid / out_stall   memory_type, undefined, source
//   cfg       in         cfg_write               cfg_index, cfg_data
//
// A register write item is written when it is accepted and gives no result.
// A disabled or fixed-range lookup goes from acceptance to the finish state, which loads the
// output register; a variable-range lookup passes the scan state first, as the range compare
// walks one range a cycle. in_stall holds from a lookup's acceptance until its result enters
// the output register, so a new lookup is not taken while one is in progress; out_stall holds
// the output register and, while a finished result waits behind it, the input too.
// Reset clears all configuration, fixed, base and mask registers at once.
`timescale 1ns / 1ps
`default_nettype none

module mtrr_memory_type_lookup
    import mtrr_pkg::*;
#(
    parameter int VAR_RANGES = VAR_RANGES_DEF,
    parameter int PHYS_BITS  = PHYS_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [2:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  command,
    input  wire logic [3:0]  reg_index,
    input  wire logic [63:0] write_data,
    input  wire logic [51:0] address,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       memory_type,
    output logic             undefined,
    output logic [1:0]       source
);

    dp_cmd_t    cmd;
    dp_status_t status;

    mtrr_ctl #(
        .VAR_RANGES (VAR_RANGES)
    ) u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    mtrr_dp #(
        .VAR_RANGES (VAR_RANGES),
        .PHYS_BITS  (PHYS_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .command     (command),
        .reg_index   (reg_index),
        .write_data  (write_data),
        .address     (address),
        .cmd         (cmd),
        .status      (status),
        .memory_type (memory_type),
        .undefined   (undefined),
        .source      (source)
    );

endmodule

`default_nettype wire
